FILE: hw/rtl/hsv2rgba_pkg.sv
// ============================================================================
// hsv2rgba_pkg: shared types and constants of the HSV to RGBA converter
// Holds the fixed-point constants, the sector code and the payload structs
// that travel between the pipeline stages.
// ============================================================================
`default_nettype none

package hsv2rgba_pkg;

    // Input field widths.
    localparam int HueW = 15;
    localparam int SatW = 16;
    localparam int ValW = 16;
    localparam int PixW = 32;

    // Fixed-point ranges.
    localparam logic [HueW-1:0] HueMax      = 15'd23039;
    localparam logic [SatW-1:0] OneQ15      = 16'd32768;
    localparam logic [11:0]     SectorUnits = 12'd3840;   // 60 degrees in 1/64 degree

    // Internal widths: chroma and min are Q1.30 (at most 2^30), channel terms
    // carry an extra factor of 3840 and stay at most 3840 * 2^30 < 2^42.
    localparam int ProdW = 31;
    localparam int TermW = 42;

    localparam logic [7:0] AlphaOpaque = 8'hFF;

    // One 60-degree hue sector.
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,   // red to yellow
        SEC_YG = 3'd1,   // yellow to green
        SEC_GC = 3'd2,   // green to cyan
        SEC_CB = 3'd3,   // cyan to blue
        SEC_BM = 3'd4,   // blue to magenta
        SEC_MR = 3'd5    // magenta to red
    } t_sector;

    // Payload after the sector stage.
    typedef struct packed {
        t_sector         sector;
        logic [11:0]     hue_dist;    // distance within sector, folded, 0..3840
        logic [SatW-1:0] sat;
        logic [ValW-1:0] val;
    } t_sec_data;

    // Payload after the chroma product.
    typedef struct packed {
        t_sector          sector;
        logic [11:0]      hue_dist;
        logic [ValW-1:0]  val;
        logic [ProdW-1:0] chroma;
    } t_chr_data;

    // Payload after min and the mid product.
    typedef struct packed {
        t_sector          sector;
        logic [ValW-1:0]  val;
        logic [ProdW-1:0] minv;
        logic [TermW-1:0] mid;     // chroma * hue_dist
    } t_mid_data;

    // Payload holding the three channel terms, scaled by 3840 * 2^30.
    typedef struct packed {
        t_sector          sector;
        logic [TermW-1:0] cx;
        logic [TermW-1:0] mx;
        logic [TermW-1:0] nx;
    } t_term_data;

endpackage

`default_nettype wire

FILE: hw/rtl/hsv2rgba_sector.sv
// ============================================================================
// hsv2rgba_sector: clamp stage and hue sector split
// Clamps the inputs, finds the 60-degree sector and the folded distance of
// the hue inside it. One register stage.
// ============================================================================
`default_nettype none

module hsv2rgba_sector (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [hsv2rgba_pkg::HueW-1:0] i_hue,
    input  wire logic [hsv2rgba_pkg::SatW-1:0] i_sat,
    input  wire logic [hsv2rgba_pkg::ValW-1:0] i_val,
    output logic                          o_ready,
    output logic                          o_valid,
    output hsv2rgba_pkg::t_sec_data       o_data,
    input  wire logic                     i_ready
);
    import hsv2rgba_pkg::*;

    logic            r_valid;
    t_sec_data       r_data;
    t_sec_data       n_data;
    logic [HueW-1:0] hue_c;
    logic [HueW-1:0] base;
    logic [11:0]     rem;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        hue_c = (i_hue > HueMax) ? HueMax : i_hue;
        if (hue_c >= HueW'(5 * SectorUnits)) begin
            n_data.sector = SEC_MR;
            base          = HueW'(5 * SectorUnits);
        end else if (hue_c >= HueW'(4 * SectorUnits)) begin
            n_data.sector = SEC_BM;
            base          = HueW'(4 * SectorUnits);
        end else if (hue_c >= HueW'(3 * SectorUnits)) begin
            n_data.sector = SEC_CB;
            base          = HueW'(3 * SectorUnits);
        end else if (hue_c >= HueW'(2 * SectorUnits)) begin
            n_data.sector = SEC_GC;
            base          = HueW'(2 * SectorUnits);
        end else if (hue_c >= HueW'(SectorUnits)) begin
            n_data.sector = SEC_YG;
            base          = HueW'(SectorUnits);
        end else begin
            n_data.sector = SEC_RY;
            base          = '0;
        end
        rem = 12'(hue_c - base);
        // Odd sectors run downward, so the mid term falls across them.
        n_data.hue_dist = n_data.sector[0] ? (SectorUnits - rem) : rem;
        n_data.sat      = (i_sat > OneQ15) ? OneQ15 : i_sat;
        n_data.val      = (i_val > OneQ15) ? OneQ15 : i_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hsv2rgba_prod.sv
// ============================================================================
// hsv2rgba_prod: chroma and mid products
// First stage forms chroma = sat * val; second stage forms min = val - chroma
// and the mid product chroma * distance. Two register stages.
// ============================================================================
`default_nettype none

module hsv2rgba_prod (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire hsv2rgba_pkg::t_sec_data  i_data,
    output logic                          o_ready,
    output logic                          o_valid,
    output hsv2rgba_pkg::t_mid_data       o_data,
    input  wire logic                     i_ready
);
    import hsv2rgba_pkg::*;

    logic      r_valid_a;
    t_chr_data r_data_a;
    t_chr_data n_data_a;
    logic      rdy_a;
    logic      r_valid_b;
    t_mid_data r_data_b;
    t_mid_data n_data_b;

    assign rdy_a   = !r_valid_b || i_ready;
    assign o_ready = !r_valid_a || rdy_a;
    assign o_valid = r_valid_b;
    assign o_data  = r_data_b;

    always_comb begin
        n_data_a.sector   = i_data.sector;
        n_data_a.hue_dist = i_data.hue_dist;
        n_data_a.val      = i_data.val;
        n_data_a.chroma   = ProdW'(32'(i_data.sat) * 32'(i_data.val));
    end

    always_comb begin
        n_data_b.sector = r_data_a.sector;
        n_data_b.val    = r_data_a.val;
        n_data_b.minv   = ProdW'({r_data_a.val, 15'd0}) - r_data_a.chroma;
        n_data_b.mid    = TermW'(r_data_a.chroma) * TermW'(r_data_a.hue_dist);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid_a <= i_valid;
            end
            if (rdy_a) begin
                r_valid_b <= r_valid_a;
            end
        end
        if (o_ready && i_valid) begin
            r_data_a <= n_data_a;
        end
        if (rdy_a && r_valid_a) begin
            r_data_b <= n_data_b;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hsv2rgba_mix.sv
// ============================================================================
// hsv2rgba_mix: channel terms, rounding and packing
// First stage builds the three channel terms scaled by 3840 * 2^30; second
// stage rounds each to 8 bits and routes them to red, green and blue.
// ============================================================================
`default_nettype none

module hsv2rgba_mix (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire hsv2rgba_pkg::t_mid_data  i_data,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [hsv2rgba_pkg::PixW-1:0] o_pixel,
    input  wire logic                     i_ready
);
    import hsv2rgba_pkg::*;

    // round(x * 255 / (3840 * 2^30)) half up; 255 / 3840 is exactly 17 / 256,
    // so this is floor((17 * x + 2^37) / 2^38).
    function automatic logic [7:0] chan_round(input logic [TermW-1:0] x);
        logic [TermW+4:0] p;
        p = ({5'd0, x} << 4) + {5'd0, x} + ((TermW+5)'(1) << 37);
        return p[45:38];
    endfunction

    logic            r_valid_a;
    t_term_data      r_data_a;
    t_term_data      n_data_a;
    logic            rdy_a;
    logic            r_valid_b;
    logic [PixW-1:0] r_pixel;
    logic [PixW-1:0] n_pixel;
    logic [7:0]      c8;
    logic [7:0]      m8;
    logic [7:0]      z8;
    logic [TermW-1:0] min_term;

    assign rdy_a   = !r_valid_b || i_ready;
    assign o_ready = !r_valid_a || rdy_a;
    assign o_valid = r_valid_b;
    assign o_pixel = r_pixel;

    always_comb begin
        min_term        = TermW'(i_data.minv) * TermW'(SectorUnits);
        n_data_a.sector = i_data.sector;
        // chroma + min equals val, so the full term needs no chroma.
        n_data_a.cx     = TermW'({i_data.val, 15'd0}) * TermW'(SectorUnits);
        n_data_a.mx     = i_data.mid + min_term;
        n_data_a.nx     = min_term;
    end

    always_comb begin
        c8 = chan_round(r_data_a.cx);
        m8 = chan_round(r_data_a.mx);
        z8 = chan_round(r_data_a.nx);
        case (r_data_a.sector)
            SEC_RY:  n_pixel = {c8, m8, z8, AlphaOpaque};
            SEC_YG:  n_pixel = {m8, c8, z8, AlphaOpaque};
            SEC_GC:  n_pixel = {z8, c8, m8, AlphaOpaque};
            SEC_CB:  n_pixel = {z8, m8, c8, AlphaOpaque};
            SEC_BM:  n_pixel = {m8, z8, c8, AlphaOpaque};
            default: n_pixel = {c8, z8, m8, AlphaOpaque};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid_a <= i_valid;
            end
            if (rdy_a) begin
                r_valid_b <= r_valid_a;
            end
        end
        if (o_ready && i_valid) begin
            r_data_a <= n_data_a;
        end
        if (rdy_a && r_valid_a) begin
            r_pixel <= n_pixel;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hsv_to_rgba_converter_top.sv
// ============================================================================
// hsv_to_rgba_converter_top: streaming HSV to packed RGBA converter
// Five-stage pipeline: one RGBA word per HSV pixel, per clock unless stalled.
// ============================================================================
// The converter takes one HSV pixel per request on the slave stream and gives
// one packed RGBA word per request on the master stream, in the same order.
// Hue is in 1/64 degree and clamps to 23039; saturation and value are Q1.15
// and clamp to 32768 (1.0). Each channel is computed exactly and rounded half
// up; alpha is always 255. The pipeline has five register stages (clamp and
// sector split, chroma product, min and mid product, channel terms, rounding
// and packing), and a new pixel can be taken every cycle unless the master
// side stalls: the sustained rate is one pixel per clock.
// Each stage holds its item while the next one is stalled and takes a new one
// as soon as it is empty or moving, so back-pressure on the master side
// propagates stage by stage and no pixel is lost or repeated.
// ============================================================================
`default_nettype none

module hsv_to_rgba_converter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: hue_angle[14:0], saturation[30:15], brightness[46:31],
    // bit 47 zero pad.
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: packed_color[31:0] (alpha, blue, green, red bytes).
    output logic [31:0]      m_axis_tdata
);
    import hsv2rgba_pkg::*;

    logic       sec_valid;
    t_sec_data  sec_data;
    logic       prod_ready;
    logic       prod_valid;
    t_mid_data  prod_data;
    logic       mix_ready;

    hsv2rgba_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_hue   (s_axis_tdata[HueW-1:0]),
        .i_sat   (s_axis_tdata[HueW+SatW-1:HueW]),
        .i_val   (s_axis_tdata[HueW+SatW+ValW-1:HueW+SatW]),
        .o_ready (s_axis_tready),
        .o_valid (sec_valid),
        .o_data  (sec_data),
        .i_ready (prod_ready)
    );

    hsv2rgba_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sec_valid),
        .i_data  (sec_data),
        .o_ready (prod_ready),
        .o_valid (prod_valid),
        .o_data  (prod_data),
        .i_ready (mix_ready)
    );

    hsv2rgba_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .i_data  (prod_data),
        .o_ready (mix_ready),
        .o_valid (m_axis_tvalid),
        .o_pixel (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

FILE: bench/hsv_to_rgba_converter_top_tb.sv
// ============================================================================
// hsv_to_rgba_converter_top_tb: self-checking bench for the HSV to RGBA stream
// Drives HSV pixel requests into the converter and checks every packed RGBA
// word against a hand-written value or an exact fixed-point predictor. A short
// table covers the color wheel corners and the clamping cases, then randomized
// pixels follow while both stream sides stall and idle at random.
// ============================================================================
`timescale 1ns / 1ps

module hsv_to_rgba_converter_top_tb;

    import hsv2rgba_pkg::*;

    localparam int RandomPixels = 1950;
    localparam int MaxReports   = 10;
    localparam int IdlePercent  = 23;
    localparam int DrainCycles  = 12;     // pipeline is five deep, leave margin

    // One row of the directed table. When known is set the expected word is
    // written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        logic [HueW-1:0] hue;
        logic [SatW-1:0] sat;
        logic [ValW-1:0] val;
        logic            known;
        logic [PixW-1:0] rgba;
    } t_pixel_case;

    localparam int NumCases = 24;
    localparam t_pixel_case DirectedCases [NumCases] = '{
        // Black and white: no chroma at all.
        '{15'd0,     16'd0,     16'd0,     1'b1, 32'h000000FF},
        '{15'd0,     16'd0,     16'd32768, 1'b1, 32'hFFFFFFFF},
        // Fully saturated primaries and secondaries on each sector start.
        '{15'd0,     16'd32768, 16'd32768, 1'b1, 32'hFF0000FF},
        '{15'd3840,  16'd32768, 16'd32768, 1'b1, 32'hFFFF00FF},
        '{15'd7680,  16'd32768, 16'd32768, 1'b1, 32'h00FF00FF},
        '{15'd11520, 16'd32768, 16'd32768, 1'b1, 32'h00FFFFFF},
        '{15'd15360, 16'd32768, 16'd32768, 1'b1, 32'h0000FFFF},
        '{15'd19200, 16'd32768, 16'd32768, 1'b1, 32'hFF00FFFF},
        // Top of the hue range and hue clamping: blue rounds down to zero.
        '{15'd23039, 16'd32768, 16'd32768, 1'b1, 32'hFF0000FF},
        '{15'd23040, 16'd32768, 16'd32768, 1'b1, 32'hFF0000FF},
        '{15'd32767, 16'd32768, 16'd32768, 1'b1, 32'hFF0000FF},
        // Saturation and brightness above one clamp to one.
        '{15'd0,     16'd65535, 16'd65535, 1'b1, 32'hFF0000FF},
        '{15'd0,     16'd32769, 16'd0,     1'b1, 32'h000000FF},
        '{15'd5000,  16'd0,     16'd65535, 1'b1, 32'hFFFFFFFF},
        // Mid terms, last unit of each sector and alternating bit patterns.
        '{15'd1920,  16'd32768, 16'd32768, 1'b0, 32'h0},
        '{15'd3839,  16'd32768, 16'd32768, 1'b0, 32'h0},
        '{15'd7679,  16'd16384, 16'd16384, 1'b0, 32'h0},
        '{15'd11519, 16'd1,     16'd1,     1'b0, 32'h0},
        '{15'd15359, 16'd32767, 16'd32767, 1'b0, 32'h0},
        '{15'd19199, 16'd20000, 16'd30000, 1'b0, 32'h0},
        '{15'd21000, 16'd12345, 16'd32768, 1'b0, 32'h0},
        '{15'd16383, 16'h7FFF,  16'h8000,  1'b0, 32'h0},
        '{15'h5555,  16'hAAAA,  16'h5555,  1'b0, 32'h0},
        '{15'h2AAA,  16'h5555,  16'hAAAA,  1'b0, 32'h0}
    };

    // Clock, reset and stream signals. Every input of the converter starts at
    // a known value before the first clock edge.
    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [47:0]     s_axis_tdata  = '0;   // hue[14:0], sat[30:15], val[46:31], pad
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [31:0]     m_axis_tdata;         // packed color: alpha, blue, green, red

    // Expected RGBA words in request order, and the bookkeeping of the check.
    logic [PixW-1:0] pending_rgba [$];
    int              fault_count   = 0;
    int              color_index   = 0;
    // While set, neither side idles, so the pipeline runs at full rate.
    bit              steady_phase  = 1'b0;

    always #5 i_clk = ~i_clk;

    hsv_to_rgba_converter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Rounds a channel term, scaled by 3840 * 2^30, to an 8-bit level with
    // half up rounding. The term never exceeds the scale, so 64 bits suffice.
    function automatic logic [7:0] level_byte(input logic [63:0] term);
        logic [63:0] scale;
        scale = 64'(SectorUnits) << 30;
        return 8'((term * 64'd255 + (scale >> 1)) / scale);
    endfunction

    // Exact HSV to RGBA conversion: clamp the inputs, find the sector and the
    // folded distance within it, then assign chroma, mid and floor terms to
    // the three channels according to the sector.
    function automatic logic [PixW-1:0] hsv_to_rgba(input logic [HueW-1:0] hue_in,
                                                    input logic [SatW-1:0] sat_in,
                                                    input logic [ValW-1:0] val_in);
        logic [HueW-1:0] hue;
        logic [SatW-1:0] sat;
        logic [ValW-1:0] val;
        logic [2:0]      sector_idx;
        logic [11:0]     offset;
        logic [11:0]     hue_dist;
        logic [63:0]     chroma;
        logic [63:0]     floor_lvl;
        logic [63:0]     peak_term;
        logic [63:0]     mid_term;
        logic [63:0]     base_term;
        logic [63:0]     red_term;
        logic [63:0]     green_term;
        logic [63:0]     blue_term;
        hue = (hue_in > HueMax) ? HueMax : hue_in;
        sat = (sat_in > OneQ15) ? OneQ15 : sat_in;
        val = (val_in > OneQ15) ? OneQ15 : val_in;

        sector_idx = 3'(hue / SectorUnits);
        offset     = 12'(hue % SectorUnits);
        // Odd sectors fall from full mid term to zero, even ones rise.
        hue_dist   = sector_idx[0] ? (SectorUnits - offset) : offset;

        chroma    = 64'(sat) * 64'(val);
        floor_lvl = (64'(val) << 15) - chroma;
        peak_term = (chroma + floor_lvl) * 64'(SectorUnits);
        mid_term  = chroma * 64'(hue_dist) + floor_lvl * 64'(SectorUnits);
        base_term = floor_lvl * 64'(SectorUnits);

        case (t_sector'(sector_idx))
            SEC_RY: begin
                red_term = peak_term; green_term = mid_term;  blue_term = base_term;
            end
            SEC_YG: begin
                red_term = mid_term;  green_term = peak_term; blue_term = base_term;
            end
            SEC_GC: begin
                red_term = base_term; green_term = peak_term; blue_term = mid_term;
            end
            SEC_CB: begin
                red_term = base_term; green_term = mid_term;  blue_term = peak_term;
            end
            SEC_BM: begin
                red_term = mid_term;  green_term = base_term; blue_term = peak_term;
            end
            default: begin
                red_term = peak_term; green_term = base_term; blue_term = mid_term;
            end
        endcase

        return {level_byte(red_term), level_byte(green_term), level_byte(blue_term),
                AlphaOpaque};
    endfunction

    // Random hue: mostly in range, some right on sector boundaries, and a
    // share over the whole 15-bit field so that clamping is exercised.
    function automatic logic [HueW-1:0] random_hue();
        int pick;
        pick = $urandom_range(0, 5) * 3840 + $urandom_range(0, 2) - 1;
        case ($urandom_range(0, 9))
            0, 1, 2: return HueW'($urandom_range(0, 32767));
            3:       return HueW'((pick < 0) ? 0 : pick);
            default: return HueW'($urandom_range(0, 23039));
        endcase
    endfunction

    // Random Q1.15 level: extremes, the full 16-bit field, or the legal range.
    function automatic logic [15:0] random_level();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 16'd0;
                    1:       return 16'd1;
                    2:       return 16'd32767;
                    3:       return 16'd32768;
                    default: return 16'd65535;
                endcase
            end
            1, 2:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic flag_fault(input string what);
        fault_count++;
        if (fault_count <= MaxReports) begin
            $display("%s", what);
        end
    endtask

    // Offers one pixel request and waits for it to be taken. The expected
    // word is queued at the edge where the request is accepted. Idle cycles
    // before the request lower tvalid; tvalid is set at most once per edge.
    task automatic send_pixel(input logic [HueW-1:0] hue, input logic [SatW-1:0] sat,
                              input logic [ValW-1:0] val, input logic known,
                              input logic [PixW-1:0] known_rgba);
        while (!steady_phase && $urandom_range(0, 99) < IdlePercent) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, sat, hue};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_rgba.push_back(known ? known_rgba : hsv_to_rgba(hue, sat, val));
    endtask

    // Holds off new requests until every queued pixel has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_rgba.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result side: check any word accepted at this edge against the oldest
    // expectation, then pick the ready level for the next cycle. Values read
    // here are those from before the edge, so the check is free of races.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rgba.size() == 0) begin
                flag_fault($sformatf("unexpected color word %08h with nothing pending",
                                     m_axis_tdata));
            end else begin
                logic [PixW-1:0] want;
                want = pending_rgba.pop_front();
                if (m_axis_tdata !== want) begin
                    flag_fault($sformatf("color %0d: expected %08h, got %08h",
                                         color_index, want, m_axis_tdata));
                end
            end
            color_index++;
        end
        m_axis_tready <= steady_phase || ($urandom_range(0, 99) >= IdlePercent);
    end

    // Stimulus: reset, directed table, then randomized pixels with a stretch
    // at full rate and a pause that lets the pipeline empty completely.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NumCases; i++) begin
            send_pixel(DirectedCases[i].hue, DirectedCases[i].sat, DirectedCases[i].val,
                       DirectedCases[i].known, DirectedCases[i].rgba);
        end
        wait_for_drain();

        for (int i = 0; i < RandomPixels; i++) begin
            steady_phase = (i >= 700 && i < 1000);
            if (i == 1400) begin
                wait_for_drain();
            end
            send_pixel(random_hue(), random_level(), random_level(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        steady_phase = 1'b0;

        // Let every queued pixel arrive, then watch a little longer for any
        // stray word the pipeline might still push out.
        while (pending_rgba.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: ends the run far beyond the time the slowest correct run takes.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
